// File: rtl/olif_pkg.sv
// ----------------------------------------------------------------------------
// olif_pkg: shared types and constants of the ordered list core
// Holds the request and response payload types, the action and status
// codes, and the per-cycle command that the top level sends to every cell.
// ----------------------------------------------------------------------------
package olif_pkg;

  // Default number of list entries.
  localparam int LIST_DEPTH_DEF = 64;

  // Field widths of the request and response.
  localparam int ValueW  = 32;
  localparam int PosW    = 6;
  localparam int ActionW = 3;
  localparam int StatusW = 2;
  localparam int CountW  = 7;

  // Number of match bits the find scanner examines per cycle.
  localparam int ScanGroup = 8;

  // Requested action.
  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_READ   = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_FIND   = 3'd4
  } action_e;

  // Response status.
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Request payload.
  typedef struct packed {
    logic [ActionW-1:0]       action;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] item_value;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic signed [ValueW-1:0] result_value;
    logic [PosW-1:0]          match_position;
    logic [StatusW-1:0]       status;
    logic [CountW-1:0]        entry_count;
  } rsp_t;

  // Command broadcast to every cell; each strobe is set only for an
  // accepted request that passed its range checks.
  typedef struct packed {
    logic ins;  // open a slot at the position, shift later entries up
    logic rem;  // close the slot at the position, shift later entries down
    logic wr;   // overwrite the entry at the position
  } cell_cmd_t;

endpackage

// File: rtl/olif_cell.sv
// ----------------------------------------------------------------------------
// olif_cell: one entry of the ordered list
// Stores one value, takes a value from its lower or upper neighbor when the
// list shifts, and reports whether it matches the searched value and its
// content when it sits at the requested position.
// ----------------------------------------------------------------------------
module olif_cell #(
  parameter int INDEX = 0,
  parameter int XW    = olif_pkg::CountW
) (
  input  logic                               clk_i,
  input  olif_pkg::cell_cmd_t                cmd_i,
  input  logic [XW-1:0]                      pos_i,
  input  logic [XW-1:0]                      count_i,
  input  logic signed [olif_pkg::ValueW-1:0] val_i,
  input  logic signed [olif_pkg::ValueW-1:0] lower_i,
  input  logic signed [olif_pkg::ValueW-1:0] upper_i,
  output logic signed [olif_pkg::ValueW-1:0] data_o,
  output logic signed [olif_pkg::ValueW-1:0] rd_o,
  output logic                               hit_o
);

  localparam logic [XW-1:0] Idx = XW'(INDEX);

  logic signed [olif_pkg::ValueW-1:0] data_q;
  logic signed [olif_pkg::ValueW-1:0] data_d;
  logic                               at_pos;
  logic                               above_pos;

  assign at_pos    = (pos_i == Idx);
  assign above_pos = (Idx > pos_i);

  // Next entry value for the shift, insert and write commands.
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (above_pos) begin
        data_d = lower_i;
      end else if (at_pos) begin
        data_d = val_i;
      end
    end
    if (cmd_i.rem && (at_pos || above_pos)) begin
      data_d = upper_i;
    end
    if (cmd_i.wr && at_pos) begin
      data_d = val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // The cell drives the shared read bus only at the requested position.
  assign rd_o   = at_pos ? data_q : '0;
  assign hit_o  = (data_q == val_i) && (Idx < count_i);
  assign data_o = data_q;

endmodule

// File: rtl/olif_scan.sv
// ----------------------------------------------------------------------------
// olif_scan: first-match scanner for the find action
// Captures one match bit per cell and walks through them a group of eight
// per cycle, reporting the lowest matching position.
// ----------------------------------------------------------------------------
module olif_scan #(
  parameter int DEPTH = olif_pkg::LIST_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic [DEPTH-1:0]           match_i,
  output logic                       hit_o,
  output logic                       last_o,
  output logic [olif_pkg::PosW-1:0]  pos_o
);

  localparam int G  = olif_pkg::ScanGroup;
  localparam int GB = $clog2(G);
  localparam int NG = (DEPTH + G - 1) / G;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int VW = NG * G;

  logic [VW-1:0] match_q;
  logic [GW-1:0] grp_q;
  logic [GB-1:0] idx;
  logic [31:0]   pos_wide;

  // Load the match vector, or shift the next group into the low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      grp_q   <= '0;
    end else if (load_i) begin
      match_q <= VW'(match_i);
      grp_q   <= '0;
    end else if (step_i) begin
      match_q <= match_q >> G;
      grp_q   <= GW'(grp_q + GW'(1));
    end
  end

  // Priority encode the current group, lowest bit first.
  always_comb begin
    idx = '0;
    for (int i = G - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        idx = GB'(i);
      end
    end
  end

  assign hit_o    = |match_q[G-1:0];
  assign last_o   = (grp_q == GW'(NG - 1));
  assign pos_wide = 32'({grp_q, idx});
  assign pos_o    = pos_wide[olif_pkg::PosW-1:0];

endmodule

// File: rtl/ordered_list_insert_remove_find_core.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_find_core: ordered list with insert, remove,
// read, write and find
// The list lives in a row of LIST_DEPTH cells, one entry per cell; on an
// insert or remove every cell above the position takes its neighbor's value
// in the same cycle; the cell at the position takes the new value or its
// upper neighbor's. Insert, remove, read and write complete in the cycle
// the request is accepted and the response appears in the output register
// in the next cycle. A find compares all cells at once and then the scanner
// walks the match bits eight cells per cycle, ending at the first match or
// the last group. One request is in flight at a time; a new request is
// taken only when the output register is empty or its response is taken in
// the same cycle, so a stalled response holds off the next request. Entries
// are only read at positions below the entry count, which are all written.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_find_core #(
  parameter int LIST_DEPTH = olif_pkg::LIST_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  olif_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output olif_pkg::rsp_t   out_rsp_o
);

  localparam int VW = olif_pkg::ValueW;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int XW = (CW > olif_pkg::CountW) ? CW : olif_pkg::CountW;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q, out_valid_d;
  olif_pkg::rsp_t     out_q, out_d;

  logic               accept;
  logic               out_free;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      count_x;
  olif_pkg::cell_cmd_t cmd;
  logic               scan_load;
  logic               scan_step;
  logic               scan_hit;
  logic               scan_last;
  logic [olif_pkg::PosW-1:0] scan_pos;

  logic signed [VW-1:0] cell_data [LIST_DEPTH];
  logic signed [VW-1:0] cell_rd   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_hit;
  logic signed [VW-1:0] rd_bus;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_x      = XW'(in_req_i.position);
  assign count_x    = XW'(count_q);

  // Row of cells, each linked to its lower and upper neighbor.
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic signed [VW-1:0] lower;
    logic signed [VW-1:0] upper;
    if (k == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[k-1];
    end
    if (k == LIST_DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[k+1];
    end
    olif_cell #(
      .INDEX (k),
      .XW    (XW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos_x),
      .count_i (count_x),
      .val_i   (in_req_i.item_value),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[k]),
      .rd_o    (cell_rd[k]),
      .hit_o   (cell_hit[k])
    );
  end

  // Shared read bus: only the cell at the position drives a nonzero value.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  // First-match scanner for find.
  olif_scan #(
    .DEPTH (LIST_DEPTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_load),
    .step_i  (scan_step),
    .match_i (cell_hit),
    .hit_o   (scan_hit),
    .last_o  (scan_last),
    .pos_o   (scan_pos)
  );

  // Request decode, cell commands and response formation.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    scan_load   = 1'b0;
    scan_step   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.result_value   = '0;
          out_d.match_position = '0;
          out_d.status         = olif_pkg::ST_OK;
          out_valid_d          = 1'b1;
          case (olif_pkg::action_e'(in_req_i.action))
            olif_pkg::ACT_INSERT: begin
              if (pos_x > count_x) begin
                out_d.status = olif_pkg::ST_RANGE;
              end else if (count_x == XW'(LIST_DEPTH)) begin
                out_d.status = olif_pkg::ST_FULL;
              end else begin
                cmd.ins = 1'b1;
                count_d = CW'(count_q + CW'(1));
              end
            end
            olif_pkg::ACT_REMOVE: begin
              if (pos_x >= count_x) begin
                out_d.status = olif_pkg::ST_RANGE;
              end else begin
                cmd.rem            = 1'b1;
                out_d.result_value = rd_bus;
                count_d            = CW'(count_q - CW'(1));
              end
            end
            olif_pkg::ACT_READ: begin
              if (pos_x >= count_x) begin
                out_d.status = olif_pkg::ST_RANGE;
              end else begin
                out_d.result_value = rd_bus;
              end
            end
            olif_pkg::ACT_WRITE: begin
              if (pos_x >= count_x) begin
                out_d.status = olif_pkg::ST_RANGE;
              end else begin
                cmd.wr = 1'b1;
              end
            end
            olif_pkg::ACT_FIND: begin
              scan_load   = 1'b1;
              out_valid_d = out_valid_q && !out_ready_i;
              state_d     = ST_SCAN;
            end
            default: begin
            end
          endcase
          out_d.entry_count = olif_pkg::CountW'(XW'(count_d));
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          if (out_free) begin
            out_d.result_value   = '0;
            out_d.match_position = scan_hit ? scan_pos : '0;
            out_d.status         = scan_hit ? olif_pkg::ST_OK : olif_pkg::ST_NOTFOUND;
            out_d.entry_count    = olif_pkg::CountW'(count_x);
            out_valid_d          = 1'b1;
            state_d              = ST_IDLE;
          end
        end else begin
          scan_step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
